@@ rtl/core/gb3_pkg.sv @@
package gb3_pkg;

    // Sizes of the beat fields and of the configuration registers.
    localparam int GB3_MAX_WIDTH   = 1024;
    localparam int GB3_PIX_W       = 8;
    localparam int GB3_FW_W        = 11;
    localparam int GB3_FH_W        = 12;
    localparam int GB3_WGT_W       = 16;
    localparam int GB3_CFG_IDX_W   = 3;
    localparam int GB3_CFG_DATA_W  = 16;
    localparam int GB3_MIN_SIZE    = 3;

    // Values after reset.
    localparam int GB3_RESET_WIDTH  = 512;
    localparam int GB3_RESET_HEIGHT = 512;
    localparam logic [GB3_WGT_W-1:0] GB3_RESET_CORNER = 16'd4923;
    localparam logic [GB3_WGT_W-1:0] GB3_RESET_EDGE   = 16'd8116;
    localparam logic [GB3_WGT_W-1:0] GB3_RESET_CENTER = 16'd13381;

    // Configuration register indexes.
    typedef enum logic [GB3_CFG_IDX_W-1:0] {
        GB3_REG_FRAME_WIDTH   = 3'd0,
        GB3_REG_FRAME_HEIGHT  = 3'd1,
        GB3_REG_CORNER_WEIGHT = 3'd2,
        GB3_REG_EDGE_WEIGHT   = 3'd3,
        GB3_REG_CENTER_WEIGHT = 3'd4
    } gb3_reg_t;

    // Beat kinds carried on s_tuser.
    localparam logic GB3_CMD_PIXEL = 1'b0;
    localparam logic GB3_CMD_DRAIN = 1'b1;

    // What the position logic decides for one accepted beat.
    typedef struct packed {
        logic                 pix_we;  // pixel enters the window and line buffers
        logic                 emit;    // beat produces a result
        logic                 border;  // result lies on the frame border
        logic                 last;    // result closes the frame
        logic [GB3_PIX_W-1:0] pixel;
    } gb3_item_t;

    // Result tag that travels alongside the window through the arithmetic.
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } gb3_tag_t;

endpackage

@@ rtl/core/gb3_ctrl.sv @@
module gb3_ctrl
    import gb3_pkg::*;
#(
    parameter int  MAX_WIDTH = GB3_MAX_WIDTH,
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WID_W     = $clog2(MAX_WIDTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 restart,
    input  logic                 accept,
    input  logic                 cmd,
    input  logic [GB3_PIX_W-1:0] pixel,
    input  logic [WID_W-1:0]     width,
    input  logic [GB3_FH_W-1:0]  height,
    output gb3_item_t            item,
    output logic [COL_W-1:0]     col
);

    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [GB3_FH_W-1:0] in_row_reg, in_row_next;
    logic                in_done_reg, in_done_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [GB3_FH_W-1:0] out_row_reg, out_row_next;

    logic [WID_W-1:0]    width_last;
    logic [GB3_FH_W-1:0] height_last;
    logic                in_col_last, in_row_last, out_col_last, out_row_last;
    logic                is_pixel, pix_emit, drain_emit;

    assign width_last  = width - WID_W'(1);
    assign height_last = height - GB3_FH_W'(1);

    assign in_col_last  = (WID_W'(in_col_reg) == width_last);
    assign in_row_last  = (in_row_reg == height_last);
    assign out_col_last = (WID_W'(out_col_reg) == width_last);
    assign out_row_last = (out_row_reg == height_last);

    // A pixel is taken until the frame is complete; results start once the
    // window's centre has a full neighbourhood behind it (width + 1 pixels).
    assign is_pixel   = (cmd == GB3_CMD_PIXEL);
    assign pix_emit   = !in_done_reg &&
                        ((in_row_reg >= GB3_FH_W'(2)) ||
                         ((in_row_reg == GB3_FH_W'(1)) && (in_col_reg != '0)));
    assign drain_emit = !is_pixel && in_done_reg;

    assign item.pix_we = is_pixel && !in_done_reg;
    assign item.emit   = (is_pixel && pix_emit) || drain_emit;
    assign item.border = (out_row_reg == '0) || out_row_last ||
                         (out_col_reg == '0) || out_col_last;
    assign item.last   = out_row_last && out_col_last;
    assign item.pixel  = pixel;
    assign col         = in_col_reg;

    // Input and output raster positions.
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (accept) begin
            if (item.pix_we) begin
                if (in_col_last) begin
                    in_col_next = '0;
                    if (in_row_last) begin
                        in_done_next = 1'b1;
                    end else begin
                        in_row_next = in_row_reg + GB3_FH_W'(1);
                    end
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (item.emit) begin
                if (item.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_done_next = 1'b0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_last) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + GB3_FH_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

@@ rtl/core/gb3_line_buf.sv @@
module gb3_line_buf
    import gb3_pkg::*;
#(
    parameter int  MAX_WIDTH = GB3_MAX_WIDTH,
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       accept,
    input  gb3_item_t                  item,
    input  logic [COL_W-1:0]           col,
    output logic [8:0][GB3_PIX_W-1:0]  win,
    output gb3_tag_t                   tag
);

    localparam int WORD_W = 2 * GB3_PIX_W;

    // Both line buffers share one word per column: upper row high, middle row low.
    logic [WORD_W-1:0]         line_mem_reg [MAX_WIDTH];
    logic [WORD_W-1:0]         rd_data_reg;
    gb3_item_t                 s1_item_reg;
    logic [COL_W-1:0]          s1_col_reg;
    logic [8:0][GB3_PIX_W-1:0] win_reg;
    gb3_tag_t                  tag_reg;

    // Read the column when the pixel is accepted and write it back from stage one
    // once the pipeline advances. Consecutive pixels always sit in different columns,
    // so the read of one pixel never meets the pending write of the one before.
    always_ff @(posedge aclk) begin
        if (en && s1_item_reg.pix_we) begin
            line_mem_reg[s1_col_reg] <= {rd_data_reg[GB3_PIX_W-1:0], s1_item_reg.pixel};
        end
        if (accept && item.pix_we) begin
            rd_data_reg <= line_mem_reg[col];
        end
    end

    // Stage one holds the beat whose column data sits in rd_data_reg.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_item_reg <= '0;
        end else if (en) begin
            s1_item_reg <= accept ? item : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && accept) begin
            s1_col_reg <= col;
        end
    end

    // Shift the window left by one column and load the new right column.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (en && s1_item_reg.pix_we) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= rd_data_reg[WORD_W-1:GB3_PIX_W];
            win_reg[5] <= rd_data_reg[GB3_PIX_W-1:0];
            win_reg[8] <= s1_item_reg.pixel;
        end
    end

    // The tag moves on with the window it belongs to.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg.emit   <= s1_item_reg.emit;
            tag_reg.border <= s1_item_reg.border;
            tag_reg.last   <= s1_item_reg.last;
        end
    end

    assign win = win_reg;
    assign tag = tag_reg;

endmodule

@@ rtl/core/gb3_mac.sv @@
module gb3_mac
    import gb3_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic [8:0][GB3_PIX_W-1:0] win,
    input  gb3_tag_t                  tag,
    input  logic [GB3_WGT_W-1:0]      corner_w,
    input  logic [GB3_WGT_W-1:0]      edge_w,
    input  logic [GB3_WGT_W-1:0]      center_w,
    output logic                      res_valid,
    output logic [GB3_PIX_W-1:0]      res_pixel,
    output logic                      res_last
);

    localparam int SUM_W  = GB3_PIX_W + 2;
    localparam int PROD_W = GB3_WGT_W + SUM_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC_W = 16;
    localparam int HI_W   = ACC_W - FRAC_W;

    logic [SUM_W-1:0]     corner_sum_reg, side_sum_reg;
    logic [GB3_PIX_W-1:0] center_reg;
    gb3_tag_t             tag_a_reg;
    logic [PROD_W-1:0]    prod_c_reg, prod_s_reg, prod_m_reg;
    gb3_tag_t             tag_b_reg;
    logic [ACC_W-1:0]     acc;
    logic [HI_W-1:0]      acc_hi;

    // Group the taps that share a weight.
    always_ff @(posedge aclk) begin
        if (en) begin
            corner_sum_reg <= SUM_W'(win[0]) + SUM_W'(win[2]) + SUM_W'(win[6]) + SUM_W'(win[8]);
            side_sum_reg   <= SUM_W'(win[1]) + SUM_W'(win[3]) + SUM_W'(win[5]) + SUM_W'(win[7]);
            center_reg     <= win[4];
        end
    end

    // One product per weight class.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_c_reg <= PROD_W'(corner_w) * PROD_W'(corner_sum_reg);
            prod_s_reg <= PROD_W'(edge_w) * PROD_W'(side_sum_reg);
            prod_m_reg <= PROD_W'(center_w) * PROD_W'(center_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end else if (en) begin
            tag_a_reg <= tag;
            tag_b_reg <= tag_a_reg;
        end
    end

    // Drop the Q0.16 fraction, saturate, and zero the frame border.
    assign acc    = ACC_W'(prod_c_reg) + ACC_W'(prod_s_reg) + ACC_W'(prod_m_reg);
    assign acc_hi = acc[ACC_W-1:FRAC_W];

    always_comb begin
        if (tag_b_reg.border) begin
            res_pixel = '0;
        end else if (acc_hi > HI_W'(255)) begin
            res_pixel = '1;
        end else begin
            res_pixel = acc_hi[GB3_PIX_W-1:0];
        end
    end

    assign res_valid = tag_b_reg.emit;
    assign res_last  = tag_b_reg.last;

endmodule

@@ rtl/core/gb3_out_buf.sv @@
module gb3_out_buf
    import gb3_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [GB3_PIX_W-1:0] in_pixel,
    input  logic                 in_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [GB3_PIX_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 full
);

    logic                 out_valid_reg, skid_valid_reg;
    logic [GB3_PIX_W-1:0] out_pixel_reg, skid_pixel_reg;
    logic                 out_last_reg, skid_last_reg;
    logic                 out_take;

    assign out_take = !out_valid_reg || m_tready;

    // Output register with one skid entry; the pipeline stops while the skid is full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            if (skid_valid_reg) begin
                out_pixel_reg <= skid_pixel_reg;
                out_last_reg  <= skid_last_reg;
            end else begin
                out_pixel_reg <= in_pixel;
                out_last_reg  <= in_last;
            end
        end else if (in_valid) begin
            skid_pixel_reg <= in_pixel;
            skid_last_reg  <= in_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;
    assign full     = skid_valid_reg;

endmodule

@@ rtl/core/gaussian_blur_3x3.sv @@
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata: pixel_in; s_tuser: cmd (1 = drain)
// m_       out        m_tvalid / m_tready  m_tdata: pixel_out; m_tlast: frame_end
// cfg_     in         cfg_valid / cfg_ready cfg_index: register; cfg_data: value
//
// Takes one beat per clock while s_tready is high; a result passes the line buffer
// read, window, sums and products registers and then the output register.
// For back-to-back pixels, the shared line buffer word of the new column is read while
// the word of the column before is written back. Reset is synchronous and clears positions,
// window, pipeline tags and configuration; the line buffer needs no clearing pass.
// When m_tready stays low, one more result lands in the skid entry and s_tready
// then drops until the output register drains.
module gaussian_blur_3x3
    import gb3_pkg::*;
#(
    parameter int MAX_WIDTH = GB3_MAX_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [GB3_PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
    input  logic                      s_tuser,   // [0] cmd
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [GB3_PIX_W-1:0]      m_tdata,   // [7:0] pixel_out
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [GB3_CFG_IDX_W-1:0]  cfg_index,
    input  logic [GB3_CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W       = (WID_W > GB3_FW_W) ? WID_W : GB3_FW_W;
    localparam int RESET_WIDTH = (GB3_RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : GB3_RESET_WIDTH;

    logic [WID_W-1:0]           width_reg, width_in;
    logic [GB3_FH_W-1:0]        height_reg, height_in;
    logic [GB3_WGT_W-1:0]       corner_reg, edge_reg, center_reg;
    logic [CMP_W-1:0]           fw_ext;
    logic                       cfg_wr, restart, en, accept;
    gb3_reg_t                   cfg_reg;
    gb3_item_t                  item;
    logic [COL_W-1:0]           col;
    logic [8:0][GB3_PIX_W-1:0]  win;
    gb3_tag_t                   tag;
    logic                       res_valid, res_last, out_full;
    logic [GB3_PIX_W-1:0]       res_pixel;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_reg   = gb3_reg_t'(cfg_index);
    assign restart   = cfg_wr &&
                       ((cfg_reg == GB3_REG_FRAME_WIDTH) || (cfg_reg == GB3_REG_FRAME_HEIGHT));

    // Frame size in use: width at least three and clamped to the line buffer, height at least three rows.
    assign fw_ext = CMP_W'(cfg_data[GB3_FW_W-1:0]);

    always_comb begin
        if (fw_ext < CMP_W'(GB3_MIN_SIZE)) begin
            width_in = WID_W'(GB3_MIN_SIZE);
        end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
            width_in = WID_W'(MAX_WIDTH);
        end else begin
            width_in = WID_W'(fw_ext);
        end
        if (cfg_data[GB3_FH_W-1:0] < GB3_FH_W'(GB3_MIN_SIZE)) begin
            height_in = GB3_FH_W'(GB3_MIN_SIZE);
        end else begin
            height_in = cfg_data[GB3_FH_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WID_W'(RESET_WIDTH);
            height_reg <= GB3_FH_W'(GB3_RESET_HEIGHT);
            corner_reg <= GB3_RESET_CORNER;
            edge_reg   <= GB3_RESET_EDGE;
            center_reg <= GB3_RESET_CENTER;
        end else if (cfg_wr) begin
            unique case (cfg_reg)
                GB3_REG_FRAME_WIDTH:   width_reg  <= width_in;
                GB3_REG_FRAME_HEIGHT:  height_reg <= height_in;
                GB3_REG_CORNER_WEIGHT: corner_reg <= cfg_data[GB3_WGT_W-1:0];
                GB3_REG_EDGE_WEIGHT:   edge_reg   <= cfg_data[GB3_WGT_W-1:0];
                GB3_REG_CENTER_WEIGHT: center_reg <= cfg_data[GB3_WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the output skid entry is occupied.
    assign en       = !out_full;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    gb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .accept  (accept),
        .cmd     (s_tuser),
        .pixel   (s_tdata),
        .width   (width_reg),
        .height  (height_reg),
        .item    (item),
        .col     (col)
    );

    gb3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .accept  (accept),
        .item    (item),
        .col     (col),
        .win     (win),
        .tag     (tag)
    );

    gb3_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .win       (win),
        .tag       (tag),
        .corner_w  (corner_reg),
        .edge_w    (edge_reg),
        .center_w  (center_reg),
        .res_valid (res_valid),
        .res_pixel (res_pixel),
        .res_last  (res_last)
    );

    gb3_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (en && res_valid),
        .in_pixel (res_pixel),
        .in_last  (res_last),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .full     (out_full)
    );

endmodule

@@ rtl/core/gb3_checker.sv @@
module gb3_checker
    import gb3_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [GB3_PIX_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The input side only stops after the output side refused a beat.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // The closing pixel of a frame is a corner, so it is always zero.
    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("frame end beat carries a nonzero pixel");

endmodule

bind gaussian_blur_3x3 gb3_checker u_gb3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ dv/tb_gaussian_blur_3x3.sv @@
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3;
    import gb3_pkg::*;

    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 2000;

    typedef struct packed {
        logic                 cmd;
        logic [GB3_PIX_W-1:0] pixel;
    } pixel_beat_t;

    typedef struct packed {
        logic [GB3_PIX_W-1:0] pixel;
        logic                 frame_end;
    } blur_result_t;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [GB3_PIX_W-1:0]      s_tdata   = '0;
    logic                      s_tuser   = GB3_CMD_PIXEL;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [GB3_PIX_W-1:0]      m_tdata;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [GB3_CFG_IDX_W-1:0]  cfg_index = GB3_REG_FRAME_WIDTH;
    logic [GB3_CFG_DATA_W-1:0] cfg_data  = '0;

    // Beats waiting for the driver and blurred pixels waiting for the block.
    pixel_beat_t  pixel_beats[$];
    blur_result_t blurred_q[$];

    int errors      = 0;
    bit idle_on     = 1'b1;
    bit beat_held   = 1'b0;
    int holds_asked = 0;
    int holds_given = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;

    // Shadow copy of the configuration registers.
    logic [GB3_FW_W-1:0]  cur_width  = GB3_FW_W'(GB3_RESET_WIDTH);
    logic [GB3_FH_W-1:0]  cur_height = GB3_FH_W'(GB3_RESET_HEIGHT);
    logic [GB3_WGT_W-1:0] w_corner   = GB3_RESET_CORNER;
    logic [GB3_WGT_W-1:0] w_edge     = GB3_RESET_EDGE;
    logic [GB3_WGT_W-1:0] w_center   = GB3_RESET_CENTER;

    // Shadow copy of the filter state.
    logic [GB3_PIX_W-1:0] row_above [GB3_MAX_WIDTH];
    logic [GB3_PIX_W-1:0] row_prev  [GB3_MAX_WIDTH];
    logic [GB3_PIX_W-1:0] taps      [9] = '{default: '0};
    int unsigned          pix_count = 0;
    int unsigned          res_count = 0;

    gaussian_blur_3x3 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned used_width();
        if (cur_width < GB3_MIN_SIZE) return GB3_MIN_SIZE;
        if (cur_width > GB3_MAX_WIDTH) return GB3_MAX_WIDTH;
        return 32'(cur_width);
    endfunction

    function automatic int unsigned used_height();
        if (cur_height < GB3_MIN_SIZE) return GB3_MIN_SIZE;
        return 32'(cur_height);
    endfunction

    // Produce the blurred pixel for the current output position and advance it.
    // Border positions give zero; the last position of the frame wraps both counters.
    function automatic void emit_blurred(input int unsigned w, input int unsigned h,
                                         output logic [GB3_PIX_W-1:0] px_out,
                                         output logic last_out);
        int unsigned row;
        int unsigned col;
        int unsigned corners;
        int unsigned sides;
        int unsigned acc;
        row = res_count / w;
        col = res_count % w;
        px_out = '0;
        if (row != 0 && row != h - 1 && col != 0 && col != w - 1) begin
            corners = int'(taps[0]) + int'(taps[2]) + int'(taps[6]) + int'(taps[8]);
            sides   = int'(taps[1]) + int'(taps[3]) + int'(taps[5]) + int'(taps[7]);
            acc = int'(w_corner) * corners + int'(w_edge) * sides
                + int'(w_center) * int'(taps[4]);
            acc = acc >> 16;
            px_out = (acc > 255) ? 8'hFF : acc[GB3_PIX_W-1:0];
        end
        last_out = (res_count + 1 >= w * h);
        res_count++;
        if (last_out) begin
            pix_count = 0;
            res_count = 0;
        end
    endfunction

    // Advance the filter by one accepted beat; returns 1 when the beat yields a result.
    function automatic bit blur_predict(input logic cmd, input logic [GB3_PIX_W-1:0] pix,
                                        output logic [GB3_PIX_W-1:0] px_out,
                                        output logic last_out);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned col;
        w = used_width();
        h = used_height();
        total = w * h;
        px_out = '0;
        last_out = 1'b0;
        if (cmd == GB3_CMD_DRAIN) begin
            if (pix_count >= total && res_count < total) begin
                emit_blurred(w, h, px_out, last_out);
                return 1'b1;
            end
            return 1'b0;
        end
        // A pixel that arrives once the whole frame is in is dropped.
        if (pix_count >= total) return 1'b0;
        col = pix_count % w;
        for (int r = 0; r < 3; r++) begin
            taps[r * 3]     = taps[r * 3 + 1];
            taps[r * 3 + 1] = taps[r * 3 + 2];
        end
        taps[2] = row_above[col];
        taps[5] = row_prev[col];
        taps[8] = pix;
        row_above[col] = row_prev[col];
        row_prev[col]  = pix;
        pix_count++;
        if (pix_count - res_count > w + 1) begin
            emit_blurred(w, h, px_out, last_out);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Input side: one beat at a time from the pending queue, with random gaps.
    always @(posedge aclk) begin : feed_proc
        logic [GB3_PIX_W-1:0] px;
        logic                 fe;
        pixel_beat_t          nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            beat_held = 1'b0;
            gap_left  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                beat_held = 1'b0;
                if (blur_predict(s_tuser, s_tdata, px, fe))
                    blurred_q.push_back({px, fe});
            end
            if (!beat_held) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_beats.size() != 0) begin
                    nxt = pixel_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.cmd;
                    s_tdata  <= nxt.pixel;
                    beat_held = 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 18);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each result beat, stall at random or on a long hold request.
    always @(posedge aclk) begin : sink_proc
        blur_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (blurred_q.size() == 0) begin
                    errors++;
                    $error("result beat with nothing expected: pixel_out %0d frame_end %0b",
                           m_tdata, m_tlast);
                end else begin
                    want = blurred_q.pop_front();
                    if (m_tdata !== want.pixel) begin
                        errors++;
                        $error("pixel_out mismatch: expected %0d, got %0d", want.pixel, m_tdata);
                    end
                    if (m_tlast !== want.frame_end) begin
                        errors++;
                        $error("frame_end mismatch: expected %0b, got %0b",
                               want.frame_end, m_tlast);
                    end
                end
            end
            if (hold_left == 0 && holds_given < holds_asked) begin
                holds_given++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_beat(input logic cmd, input logic [GB3_PIX_W-1:0] pix);
        pixel_beats.push_back({cmd, pix});
    endtask

    // Wait until every beat is taken and every result is back, then let the pipe empty.
    task automatic settle();
        do @(posedge aclk);
        while (pixel_beats.size() != 0 || beat_held || blurred_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input gb3_reg_t idx, input logic [GB3_CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            GB3_REG_FRAME_WIDTH: begin
                cur_width = val[GB3_FW_W-1:0];
                pix_count = 0;
                res_count = 0;
            end
            GB3_REG_FRAME_HEIGHT: begin
                cur_height = val[GB3_FH_W-1:0];
                pix_count = 0;
                res_count = 0;
            end
            GB3_REG_CORNER_WEIGHT: w_corner = val;
            GB3_REG_EDGE_WEIGHT:   w_edge   = val;
            GB3_REG_CENTER_WEIGHT: w_center = val;
            default: ;
        endcase
    endtask

    task automatic set_size(input logic [GB3_CFG_DATA_W-1:0] wv,
                            input logic [GB3_CFG_DATA_W-1:0] hv);
        write_reg(GB3_REG_FRAME_WIDTH, wv);
        write_reg(GB3_REG_FRAME_HEIGHT, hv);
    endtask

    task automatic set_weights(input logic [GB3_WGT_W-1:0] c, input logic [GB3_WGT_W-1:0] e,
                               input logic [GB3_WGT_W-1:0] m);
        write_reg(GB3_REG_CORNER_WEIGHT, c);
        write_reg(GB3_REG_EDGE_WEIGHT, e);
        write_reg(GB3_REG_CENTER_WEIGHT, m);
    endtask

    function automatic logic [GB3_WGT_W-1:0] pick_weight(input logic [GB3_WGT_W-1:0] dflt);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return GB3_WGT_W'($urandom);
            default: return dflt;
        endcase
    endfunction

    function automatic logic [GB3_PIX_W-1:0] pick_pixel(input int style);
        case (style)
            1: return '0;
            2: return '1;
            3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            4: return GB3_PIX_W'($urandom_range(0, 15));
            default: return GB3_PIX_W'($urandom);
        endcase
    endfunction

    // One whole frame: pixels with stray early drains, sometimes surplus pixels that
    // must be dropped, the tail drains, and sometimes a drain with nothing pending.
    task automatic send_frame(input int style, output int useful);
        int unsigned w;
        int unsigned h;
        w = used_width();
        h = used_height();
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 19) == 0) queue_beat(GB3_CMD_DRAIN, GB3_PIX_W'($urandom));
            queue_beat(GB3_CMD_PIXEL, pick_pixel(style));
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) queue_beat(GB3_CMD_PIXEL, GB3_PIX_W'($urandom));
        repeat (w + 1) queue_beat(GB3_CMD_DRAIN, GB3_PIX_W'($urandom));
        if ($urandom_range(0, 9) == 0) queue_beat(GB3_CMD_DRAIN, GB3_PIX_W'($urandom));
        useful = w * h + w + 1;
    endtask

    initial begin : stim_proc
        logic [GB3_PIX_W-1:0]      dir_pix [9];
        logic [GB3_CFG_DATA_W-1:0] wv;
        int counted;
        int chunk;
        int n;
        dir_pix = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55};
        counted = 0;
        chunk   = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a drain before the frame is in and two pixels, no results.
        queue_beat(GB3_CMD_DRAIN, 8'h3C);
        queue_beat(GB3_CMD_PIXEL, 8'h00);
        queue_beat(GB3_CMD_PIXEL, 8'hFF);
        settle();

        // Sizes below the minimum clamp to 3x3. One interior pixel, an early drain,
        // a pixel after the full frame, the tail, then a drain with nothing pending.
        set_size(16'd0, 16'd1);
        for (int i = 0; i < 9; i++) begin
            queue_beat(GB3_CMD_PIXEL, dir_pix[i]);
            if (i == 4) queue_beat(GB3_CMD_DRAIN, 8'hFF);
        end
        queue_beat(GB3_CMD_PIXEL, 8'hAA);
        repeat (4) queue_beat(GB3_CMD_DRAIN, 8'h00);
        queue_beat(GB3_CMD_DRAIN, 8'h81);
        settle();

        // Widest line buffer: width above the maximum clamps to the maximum.
        set_size(16'h07FF, 16'd3);
        send_frame(0, n);
        settle();

        // Tallest frame, with upper data bits set, fed only in part.
        set_size(16'hF803, 16'hFFFF);
        repeat (60) queue_beat(GB3_CMD_PIXEL, GB3_PIX_W'($urandom));
        settle();

        // Full-scale weights saturate; the output side holds off meanwhile.
        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_size(16'd5, 16'd4);
        holds_asked++;
        send_frame(2, n);
        send_frame(3, n);
        settle();

        // Zero weights, then back to the usual kernel.
        set_weights(16'd0, 16'd0, 16'd0);
        send_frame(0, n);
        settle();
        set_weights(GB3_RESET_CORNER, GB3_RESET_EDGE, GB3_RESET_CENTER);

        // Random part: mostly whole frames, some cut short and restarted.
        while (counted < RANDOM_ITEMS) begin
            chunk++;
            idle_on = (chunk % 5 != 0) && (counted < RANDOM_ITEMS - 200);
            settle();
            if (chunk % 2 == 1) begin
                case ($urandom_range(0, 9))
                    0:       wv = GB3_CFG_DATA_W'($urandom_range(0, 2));
                    1, 2:    wv = GB3_CFG_DATA_W'($urandom_range(13, 40));
                    default: wv = GB3_CFG_DATA_W'($urandom_range(3, 12));
                endcase
                set_size(wv, GB3_CFG_DATA_W'($urandom_range(0, 7)));
                set_weights(pick_weight(GB3_RESET_CORNER), pick_weight(GB3_RESET_EDGE),
                            pick_weight(GB3_RESET_CENTER));
            end
            if (chunk == 4) holds_asked++;
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, used_width() * used_height() - 1);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0)
                            queue_beat(GB3_CMD_DRAIN, GB3_PIX_W'($urandom));
                        queue_beat(GB3_CMD_PIXEL, GB3_PIX_W'($urandom));
                    end
                    // Rewriting the size restarts the frame.
                    settle();
                    set_size(GB3_CFG_DATA_W'(cur_width), GB3_CFG_DATA_W'(cur_height));
                end else begin
                    send_frame($urandom_range(0, 4), n);
                    counted += n;
                end
            end
        end

        // Drain everything and look for leftovers or stray results.
        idle_on = 1'b0;
        do @(posedge aclk);
        while (pixel_beats.size() != 0 || beat_held);
        for (int k = 0; k < 2000 && blurred_q.size() != 0; k++) @(posedge aclk);
        if (blurred_q.size() != 0) begin
            errors++;
            $error("%0d expected results never arrived", blurred_q.size());
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/gb3_pkg.sv
rtl/core/gb3_ctrl.sv
rtl/core/gb3_line_buf.sv
rtl/core/gb3_mac.sv
rtl/core/gb3_out_buf.sv
rtl/core/gaussian_blur_3x3.sv
rtl/core/gb3_checker.sv
dv/tb_gaussian_blur_3x3.sv
